### rtl/core/wmat_pkg.sv
// ---------------------------------------------------------------------------
// wmat_pkg
// Shared types and constants for the wear/motion alarm tracker.
// ---------------------------------------------------------------------------
package wmat_pkg;

   localparam int VARIANCE_BITS = 24;
   localparam int CMP_BITS      = (VARIANCE_BITS > 24) ? VARIANCE_BITS : 24;

   // still-count / wear decay
   localparam logic [6:0] STILL_CAP       = 7'd120;
   localparam logic [6:0] DECAY_START     = 7'd60;
   localparam logic [6:0] MODERATE_CREDIT = 7'd30;
   localparam logic [6:0] WORN_FULL       = 7'd100;
   localparam logic [6:0] WORN_MIN        = 7'd40;

   // motion classification
   localparam logic [CMP_BITS-1:0] IMPACT_VARIANCE = CMP_BITS'(80000);
   localparam logic [CMP_BITS-1:0] HARD_VARIANCE   = CMP_BITS'(30000);
   localparam logic [15:0]         HARD_RMS        = 16'd480;
   localparam logic [9:0]          FREQ_LOW        = 10'd16;
   localparam logic [9:0]          FREQ_HIGH       = 10'd48;
   localparam logic [7:0]          PEAK_MIN        = 8'd90;
   localparam logic [7:0]          RESTRAIN_RUN    = 8'd6;

   // alarm run
   localparam logic [7:0] RUN_MAX   = 8'd255;
   localparam logic [7:0] RUN_HIGH  = 8'd11;
   localparam logic [7:0] RUN_MID   = 8'd8;
   localparam logic [6:0] CONF_HIGH = 7'd99;
   localparam logic [6:0] CONF_MID  = 7'd66;
   localparam logic [6:0] CONF_LOW  = 7'd33;

   // motion_state bit positions
   localparam int MOT_STILL      = 0;
   localparam int MOT_PERIODIC   = 1;
   localparam int MOT_APERIODIC  = 2;
   localparam int MOT_IMPACT     = 3;
   localparam int MOT_RESTRAINED = 4;
   localparam int MOT_MODEL      = 7;

   typedef enum logic [1:0] {
      CSR_ANOMALY_THRESHOLD  = 2'd0,
      CSR_HYST_LEN           = 2'd1,
      CSR_STILL_LIMIT        = 2'd2,
      CSR_ACTIVE_LIMIT       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [VARIANCE_BITS-1:0] var_trace;
      logic [15:0]              resultant_rms;
      logic [9:0]               dominant_freq;
      logic [7:0]               spectral_peak;
      logic [15:0]              anomaly_score;
      logic                     event_acknowledged;
      logic                     model_ready;
   } req_type;

   typedef struct packed {
      logic [6:0] wear_confidence;
      logic [7:0] motion_state;
      logic [7:0] scaled_score;
      logic [7:0] alarm_windows;
      logic       threat_event;
      logic [6:0] alert_confidence;
      logic       clear_ack;
   } rsp_type;

   // classified window handed from front to back
   typedef struct packed {
      logic       still;
      logic       active;
      logic       impact;
      logic       periodic;
      logic       score_hi;
      logic [7:0] score_sat;
      logic       acked;
      logic       ready;
   } cls_type;

endpackage

### rtl/core/wmat_fifo.sv
// ---------------------------------------------------------------------------
// wmat_fifo
// Small register-based synchronous FIFO, one push and one pop per cycle.
// ---------------------------------------------------------------------------
module wmat_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fifo count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fifo count missed a push");

   a_ptr_sync: assert property (@(posedge clock) disable iff (reset)
      empty |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("fifo pointers differ while empty");

endmodule

### rtl/core/wmat_front.sv
// ---------------------------------------------------------------------------
// wmat_front
// Config registers and per-window classification (stateless compares).
// ---------------------------------------------------------------------------
module wmat_front
   import wmat_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [23:0]   csr_wdata,
   input  req_type       req_data,
   output cls_type       cls,
   output logic [7:0]    hyst_len
);

   logic [15:0] anomaly_threshold_ff;
   logic [7:0]  hyst_len_ff;
   logic [23:0] still_limit_ff;
   logic [23:0] active_limit_ff;
   logic [CMP_BITS-1:0] var_ext;

   assign csr_ready = 1'b1;
   assign hyst_len  = hyst_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         anomaly_threshold_ff <= 16'd113;
         hyst_len_ff          <= 8'd5;
         still_limit_ff       <= 24'd100;
         active_limit_ff      <= 24'd1000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ANOMALY_THRESHOLD: anomaly_threshold_ff <= csr_wdata[15:0];
            CSR_HYST_LEN:          hyst_len_ff          <= csr_wdata[7:0];
            CSR_STILL_LIMIT:       still_limit_ff       <= csr_wdata;
            CSR_ACTIVE_LIMIT:      active_limit_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      var_ext      = CMP_BITS'(req_data.var_trace);
      cls.still    = var_ext < CMP_BITS'(still_limit_ff);
      cls.active   = var_ext > CMP_BITS'(active_limit_ff);
      cls.impact   = (var_ext > IMPACT_VARIANCE) ||
                     ((req_data.resultant_rms > HARD_RMS) && (var_ext > HARD_VARIANCE));
      cls.periodic = (req_data.dominant_freq >= FREQ_LOW) &&
                     (req_data.dominant_freq <= FREQ_HIGH) &&
                     (req_data.spectral_peak >= PEAK_MIN);
      // a zeroed score never exceeds the threshold, so the back only masks this
      cls.score_hi  = req_data.anomaly_score > anomaly_threshold_ff;
      cls.score_sat = (req_data.anomaly_score > 16'd255) ? 8'd255
                                                         : req_data.anomaly_score[7:0];
      cls.acked     = req_data.event_acknowledged;
      cls.ready     = req_data.model_ready;
   end

endmodule

### rtl/core/wmat_back.sv
// ---------------------------------------------------------------------------
// wmat_back
// Still/wear/run state update; one window per cycle unless rsp_full stalls it.
// ---------------------------------------------------------------------------
module wmat_back
   import wmat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cls_type    cls,
   input  logic       cls_valid,
   output logic       cls_pop,
   input  logic [7:0] hyst_len,
   output rsp_type    rsp,
   output logic       rsp_push,
   input  logic       rsp_full
);

   logic [6:0]  still_windows_ff, still_windows_in;
   logic [6:0]  worn_percent_ff, worn_percent_in;
   logic [7:0]  anomaly_run_ff, anomaly_run_in;

   logic [6:0]  remain;
   logic [8:0]  remain_x5;
   logic [18:0] third;
   logic        suppress, anomalous, threat, clear;
   logic [6:0]  conf;
   logic [7:0]  motion;

   assign cls_pop  = cls_valid && !rsp_full;
   assign rsp_push = cls_pop;

   always_comb begin
      // still count
      priority if (cls.still) begin
         still_windows_in = (still_windows_ff < STILL_CAP) ? still_windows_ff + 7'd1
                                                           : still_windows_ff;
      end else if (cls.active) begin
         still_windows_in = '0;
      end else begin
         still_windows_in = (still_windows_ff > MODERATE_CREDIT) ?
                            still_windows_ff - MODERATE_CREDIT : '0;
      end

      // decay: floor((120 - c) * 5 / 3), divide by 3 as * 683 >> 11 (exact to 300)
      remain    = STILL_CAP - still_windows_in;
      remain_x5 = 9'(remain) * 9'd5;
      third     = 19'(remain_x5) * 19'd683;

      priority if (still_windows_in > DECAY_START) begin
         worn_percent_in = third[17:11];
      end else if (!cls.still) begin
         worn_percent_in = WORN_FULL;
      end else begin
         worn_percent_in = worn_percent_ff;
      end

      suppress  = (cls.still || (worn_percent_in < WORN_MIN)) && (anomaly_run_ff == '0);
      anomalous = cls.score_hi && !suppress && (worn_percent_in >= WORN_MIN);

      motion = '0;
      priority if (cls.still) begin
         motion[MOT_STILL] = 1'b1;
      end else if (cls.impact) begin
         motion[MOT_IMPACT] = 1'b1;
      end else if (cls.periodic) begin
         motion[MOT_PERIODIC] = 1'b1;
      end else begin
         motion[MOT_APERIODIC] = 1'b1;
      end
      motion[MOT_RESTRAINED] = (anomaly_run_ff > RESTRAIN_RUN) && cls.still;
      motion[MOT_MODEL]      = cls.ready;

      threat = 1'b0;
      clear  = 1'b0;
      conf   = '0;
      anomaly_run_in = anomaly_run_ff;
      if (anomalous) begin
         if (anomaly_run_ff != RUN_MAX) begin
            anomaly_run_in = anomaly_run_ff + 8'd1;
         end
         if ((anomaly_run_in >= hyst_len) && !cls.acked) begin
            threat = 1'b1;
            priority if (anomaly_run_in >= RUN_HIGH) begin
               conf = CONF_HIGH;
            end else if (anomaly_run_in >= RUN_MID) begin
               conf = CONF_MID;
            end else begin
               conf = CONF_LOW;
            end
         end
      end else if (anomaly_run_ff != '0) begin
         anomaly_run_in = '0;
         clear          = 1'b1;
      end

      rsp.wear_confidence  = worn_percent_in;
      rsp.motion_state     = motion;
      rsp.scaled_score     = suppress ? 8'd0 : cls.score_sat;
      rsp.alarm_windows    = anomaly_run_in;
      rsp.threat_event     = threat;
      rsp.alert_confidence = conf;
      rsp.clear_ack        = clear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         still_windows_ff <= '0;
         worn_percent_ff  <= '0;
         anomaly_run_ff   <= '0;
      end else if (cls_pop) begin
         still_windows_ff <= still_windows_in;
         worn_percent_ff  <= worn_percent_in;
         anomaly_run_ff   <= anomaly_run_in;
      end
   end

   a_threat_conf: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp.threat_event == (rsp.alert_confidence != '0)))
      else $error("threat and confidence disagree");

   a_clear_resets_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp.clear_ack) |=> (anomaly_run_ff == '0))
      else $error("run not cleared after clear pulse");

   a_state_bounds: assert property (@(posedge clock) disable iff (reset)
      (still_windows_ff <= STILL_CAP) && (worn_percent_ff <= WORN_FULL))
      else $error("still count or wear out of range");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !$past(cls_pop) && !$past(reset) |-> $stable(anomaly_run_ff))
      else $error("run changed without a request");

endmodule

### rtl/core/wear_motion_alarm_tracker_core.sv
// ---------------------------------------------------------------------------
// wear_motion_alarm_tracker_core
// Window summary in, wear/motion/alarm result out; front classifies,
// back updates the still/wear/run state, queues in between and at output.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  request   push / full          req_data  (req_type)
//  result    empty / pop          rsp_data  (rsp_type)
//  csr       csr_valid/csr_ready  csr_index, csr_wdata
//
// One request per cycle sustained while pop keeps up; a result shows once
// its request has passed the mid queue, then the result queue, and can then pop.
// The back state update loops through its own registers and sets the rate.
// Reset clears the state and loads the register defaults; no clearing pass.
// full rises when the mid queue fills, which happens only while pop stalls.
// ---------------------------------------------------------------------------
module wear_motion_alarm_tracker_core
   import wmat_pkg::*;
#(
   parameter int MID_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  req_type       req_data,
   output logic          empty,
   input  logic          pop,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [23:0]   csr_wdata
);

   cls_type    cls_front, cls_head;
   logic       mid_empty, cls_pop;
   logic [7:0] hyst_len;
   rsp_type    rsp_back;
   logic       rsp_push, rsp_full;

   wmat_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cls       (cls_front),
      .hyst_len  (hyst_len)
   );

   wmat_fifo #(
      .WIDTH ($bits(cls_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (cls_front),
      .full  (full),
      .pop   (cls_pop),
      .rdata (cls_head),
      .empty (mid_empty)
   );

   wmat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls       (cls_head),
      .cls_valid (!mid_empty),
      .cls_pop   (cls_pop),
      .hyst_len  (hyst_len),
      .rsp       (rsp_back),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   wmat_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_back),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_data),
      .empty (empty)
   );

endmodule

### tb/wear_motion_alarm_tracker_core_tb.sv
// ---------------------------------------------------------------------------
// wear_motion_alarm_tracker_core_tb
// Self-checking bench for the wear/motion alarm tracker. A short table of
// directed windows is followed by random window sequences (still stretches,
// alarm runs, moderate and noisy windows) under several register settings.
// Typed rows are checked field by field against fixed values, others against a
// model of still count, wear decay, score suppression, motion mask and run.
// ---------------------------------------------------------------------------
module wear_motion_alarm_tracker_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wmat_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_WINDOWS = 90;
   localparam int LONG_RUN      = 270;
   localparam int REQ_BITS      = $bits(req_type);

   // tracker rules
   localparam int unsigned CAP_STILL      = 120;
   localparam int unsigned START_DECAY    = 60;
   localparam int unsigned SPAN_DECAY     = 60;
   localparam int unsigned CREDIT_MOD     = 30;
   localparam int unsigned MIN_WORN       = 40;
   localparam int unsigned VAR_IMPACT     = 80000;
   localparam int unsigned VAR_HARD       = 30000;
   localparam int unsigned RMS_HARD       = 480;
   localparam int unsigned FREQ_MIN       = 16;
   localparam int unsigned FREQ_MAX       = 48;
   localparam int unsigned PEAK_FLOOR     = 90;
   localparam int unsigned RUN_RESTRAINED = 6;
   localparam int unsigned RUN_SAT        = 255;

   typedef enum logic [1:0] {WIN_STILL, WIN_MODERATE, WIN_ACTIVE, WIN_NOISE} win_kind_type;

   typedef struct packed {
      req_type win;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   logic          clock;
   logic          reset     = 1'b1;
   logic          push      = 1'b0;
   logic          full;
   req_type       req_data  = '0;
   logic          empty;
   logic          pop       = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_ANOMALY_THRESHOLD;
   logic [23:0]   csr_wdata = '0;

   // model state and register copy
   logic [6:0]  still_cnt      = '0;
   logic [6:0]  worn_pct       = '0;
   logic [7:0]  run_len        = '0;
   logic [15:0] cfg_thresh     = 16'd113;
   logic [7:0]  cfg_hyst       = 8'd5;
   logic [23:0] cfg_still_lim  = 24'd100;
   logic [23:0] cfg_active_lim = 24'd1000;

   rsp_type     pending_results[$];
   dir_row_type directed_rows[32];
   int          n_rows      = 0;
   int          failures    = 0;
   int          cycle_count = 0;
   int          burst_left  = 0;
   int          rx_mode     = 0;
   int          rx_cycle    = 0;
   int          stall_left  = 0;

   wear_motion_alarm_tracker_core u_top (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Predicts one result and advances the still/wear/run state.
   function automatic rsp_type track_window(input req_type w);
      rsp_type     r;
      logic        still_win;
      logic [7:0]  prev_run;
      logic [15:0] score;
      r         = '0;
      prev_run  = run_len;
      score     = w.anomaly_score;
      still_win = w.var_trace < cfg_still_lim;

      if (still_win) begin
         if (still_cnt < CAP_STILL) still_cnt = still_cnt + 7'd1;
      end else if (w.var_trace > cfg_active_lim) begin
         still_cnt = '0;
         worn_pct  = 7'd100;
      end else begin
         still_cnt = (still_cnt > CREDIT_MOD) ? still_cnt - 7'(CREDIT_MOD) : 7'd0;
         if (still_cnt <= START_DECAY) worn_pct = 7'd100;
      end
      // linear decay; still_cnt never exceeds the cap, so no clamp needed
      if (still_cnt > START_DECAY)
         worn_pct = 7'(((START_DECAY + SPAN_DECAY - int'(still_cnt)) * 100) / SPAN_DECAY);

      if ((still_win || worn_pct < MIN_WORN) && prev_run == 0) score = '0;

      if (still_win)
         r.motion_state[MOT_STILL] = 1'b1;
      else if (w.var_trace > VAR_IMPACT ||
               (w.resultant_rms > RMS_HARD && w.var_trace > VAR_HARD))
         r.motion_state[MOT_IMPACT] = 1'b1;
      else if (w.dominant_freq >= FREQ_MIN && w.dominant_freq <= FREQ_MAX &&
               w.spectral_peak >= PEAK_FLOOR)
         r.motion_state[MOT_PERIODIC] = 1'b1;
      else
         r.motion_state[MOT_APERIODIC] = 1'b1;
      if (prev_run > RUN_RESTRAINED && still_win) r.motion_state[MOT_RESTRAINED] = 1'b1;
      if (w.model_ready) r.motion_state[MOT_MODEL] = 1'b1;

      if (score > cfg_thresh && worn_pct >= MIN_WORN) begin
         if (run_len != RUN_SAT) run_len = run_len + 8'd1;
         if (run_len >= cfg_hyst && !w.event_acknowledged) begin
            r.threat_event     = 1'b1;
            r.alert_confidence = (run_len >= 11) ? 7'd99 : (run_len >= 8) ? 7'd66 : 7'd33;
         end
      end else if (run_len != 0) begin
         run_len     = '0;
         r.clear_ack = 1'b1;
      end

      r.wear_confidence = worn_pct;
      r.scaled_score    = (score > 255) ? 8'd255 : score[7:0];
      r.alarm_windows   = run_len;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // result side: checks popped results and stalls pop in a random pattern
   always @(posedge clock) begin : rx_side
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (pending_results.size() == 0) begin
               $error("result with no request outstanding: %p", rsp_data);
               failures++;
            end else begin
               want = pending_results.pop_front();
               check_field("wear_confidence", want.wear_confidence, rsp_data.wear_confidence);
               check_field("motion_state", want.motion_state, rsp_data.motion_state);
               check_field("scaled_score", want.scaled_score, rsp_data.scaled_score);
               check_field("alarm_windows", want.alarm_windows, rsp_data.alarm_windows);
               check_field("threat_event", want.threat_event, rsp_data.threat_event);
               check_field("alert_confidence", want.alert_confidence,
                           rsp_data.alert_confidence);
               check_field("clear_ack", want.clear_ack, rsp_data.clear_ack);
            end
         end
         rx_cycle++;
         if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
         if (stall_left != 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 2);
            pop <= 1'b0;
         end else if (rx_mode == 2 && $urandom_range(0, 1) == 0) begin
            stall_left = $urandom_range(0, 11);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Sends one request in the current burst, opening a new burst after a gap.
   task automatic send_window(input req_type w, input logic typed, input rsp_type want);
      rsp_type predicted;
      int      gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push     <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (full);
      predicted = track_window(w);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Drops push and waits until every result is back.
   task automatic settle();
      push       <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] thr, input logic [7:0] hys,
                             input logic [23:0] sl, input logic [23:0] al);
      csr_index_type idx;
      logic [23:0]   data;
      int            k;
      for (k = 0; k < 4; k++) begin
         idx = csr_index_type'(k);
         // junk above the register width must be dropped
         case (idx)
            CSR_ANOMALY_THRESHOLD: data = {8'($urandom), thr};
            CSR_HYST_LEN:          data = {16'($urandom), hys};
            CSR_STILL_LIMIT:       data = sl;
            default:               data = al;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
         do @(posedge clock); while (!csr_ready);
         case (idx)
            CSR_ANOMALY_THRESHOLD: cfg_thresh     = data[15:0];
            CSR_HYST_LEN:          cfg_hyst       = data[7:0];
            CSR_STILL_LIMIT:       cfg_still_lim  = data;
            default:               cfg_active_lim = data;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_score(input logic hot);
      int unsigned lo;
      if (!hot) return 16'($urandom_range(cfg_thresh, 0));
      if (cfg_thresh == 16'hFFFF) return 16'hFFFF;
      lo = cfg_thresh + 1;
      if ($urandom_range(0, 7) == 0) return 16'($urandom_range(65535, lo));
      return 16'($urandom_range((lo + 400 > 65535) ? 65535 : lo + 400, lo));
   endfunction

   function automatic req_type make_window(input win_kind_type kind, input logic hot,
                                           input logic acked);
      req_type     w;
      int unsigned lo;
      int unsigned hi;
      w = req_type'(REQ_BITS'({$urandom, $urandom, $urandom}));
      if (kind == WIN_NOISE) return w;
      case ($urandom_range(0, 2))
         0:       w.resultant_rms = 16'($urandom_range(480, 0));
         1:       w.resultant_rms = 16'($urandom_range(700, 481));
         default: ;
      endcase
      if ($urandom_range(0, 1) == 0) begin
         w.dominant_freq = 10'($urandom_range(FREQ_MAX, FREQ_MIN));
         w.spectral_peak = 8'($urandom_range(255, PEAK_FLOOR));
      end
      w.anomaly_score      = pick_score(hot);
      w.event_acknowledged = acked;
      case (kind)
         WIN_STILL: begin
            if (cfg_still_lim != 0) w.var_trace = 24'($urandom_range(cfg_still_lim - 1, 0));
         end
         WIN_MODERATE: begin
            if (cfg_still_lim <= cfg_active_lim)
               w.var_trace = 24'($urandom_range(cfg_active_lim, cfg_still_lim));
         end
         default: begin
            if (cfg_active_lim == 24'hFFFFFF) begin
               w.var_trace = 24'hFFFFFF;
            end else begin
               lo = cfg_active_lim + 1;
               hi = ($urandom_range(0, 1) == 0 && lo + 100000 < 24'hFFFFFF) ? lo + 100000
                                                                            : 24'hFFFFFF;
               w.var_trace = 24'($urandom_range(hi, lo));
            end
         end
      endcase
      return w;
   endfunction

   // Random sequences: alarm runs, still stretches, moderate, quiet and noise.
   task automatic run_phase(input int quota);
      int   sent;
      int   len;
      int   ack_mode;
      int   i;
      logic acked;
      sent = 0;
      while (sent < quota) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               len      = $urandom_range(1, 16);
               ack_mode = $urandom_range(0, 3);
               for (i = 0; i < len; i++) begin
                  acked = (ack_mode == 3) || (ack_mode == 2 && $urandom_range(0, 3) == 0);
                  send_window(make_window(WIN_ACTIVE, 1'b1, acked), 1'b0, '0);
               end
            end
            4, 5: begin
               len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 130)
                                                 : $urandom_range(1, 20);
               for (i = 0; i < len; i++)
                  send_window(make_window(WIN_STILL, 1'($urandom), 1'($urandom)), 1'b0, '0);
            end
            6: begin
               len = $urandom_range(1, 8);
               for (i = 0; i < len; i++)
                  send_window(make_window(WIN_MODERATE, 1'($urandom), 1'($urandom)),
                              1'b0, '0);
            end
            7: begin
               len = $urandom_range(1, 6);
               for (i = 0; i < len; i++)
                  send_window(make_window(WIN_ACTIVE, 1'b0, 1'($urandom)), 1'b0, '0);
            end
            default: begin
               len = $urandom_range(1, 4);
               for (i = 0; i < len; i++)
                  send_window(make_window(WIN_NOISE, 1'b0, 1'b0), 1'b0, '0);
            end
         endcase
         sent += len;
      end
   endtask

   function automatic req_type window_of(input logic [23:0] v, input logic [15:0] rms,
                                         input logic [9:0] freq, input logic [7:0] peak,
                                         input logic [15:0] score, input logic acked,
                                         input logic ready);
      return '{v, rms, freq, peak, score, acked, ready};
   endfunction

   function automatic rsp_type outcome(input logic [6:0] worn, input logic [7:0] motion,
                                       input logic [7:0] score, input logic [7:0] run,
                                       input logic threat, input logic [6:0] conf,
                                       input logic clear);
      return '{worn, motion, score, run, threat, conf, clear};
   endfunction

   task automatic add_row(input req_type w, input logic typed, input rsp_type want);
      directed_rows[n_rows] = '{w, typed, want};
      n_rows++;
   endtask

   initial begin : stimulus
      logic [15:0] thr;
      logic [7:0]  hys;
      logic [23:0] sl;
      logic [23:0] al;
      int          phase;
      int          i;

      // default registers: threshold 113, hysteresis 5, limits 100 / 1000
      add_row(window_of(24'd0, 16'd0, 10'd0, 8'd0, 16'd0, 1'b0, 1'b0), 1'b1,
              outcome(7'd0, 8'h01, 8'd0, 8'd0, 1'b0, 7'd0, 1'b0));
      add_row(window_of(24'hFFFFFF, 16'hFFFF, 10'h3FF, 8'hFF, 16'hFFFF, 1'b1, 1'b1), 1'b1,
              outcome(7'd100, 8'h88, 8'd255, 8'd1, 1'b0, 7'd0, 1'b0));
      // run grows through all three alert levels
      repeat (11) add_row(window_of(24'd5000, 16'd100, 10'd32, 8'd120, 16'd200, 1'b0, 1'b0),
                          1'b0, '0);
      // still after a long run: restrained bit and clear pulse
      add_row(window_of(24'd0, 16'd0, 10'd0, 8'd0, 16'd0, 1'b0, 1'b1), 1'b0, '0);
      add_row(window_of(24'd40000, 16'd481, 10'd0, 8'd0, 16'd50, 1'b0, 1'b0), 1'b0, '0);
      add_row(window_of(24'd30000, 16'd481, 10'd0, 8'd0, 16'd50, 1'b0, 1'b0), 1'b0, '0);
      add_row(window_of(24'd1000, 16'd0, 10'd16, 8'd90, 16'd113, 1'b0, 1'b0), 1'b0, '0);
      add_row(window_of(24'd100, 16'd0, 10'd48, 8'd89, 16'd114, 1'b0, 1'b0), 1'b0, '0);
      add_row(window_of(24'd80001, 16'd480, 10'd49, 8'd255, 16'hFFFF, 1'b0, 1'b1), 1'b0, '0);
      // acknowledged run: no threat at the hysteresis count
      repeat (3) add_row(window_of(24'd2000, 16'd0, 10'd15, 8'd90, 16'd300, 1'b1, 1'b0),
                         1'b0, '0);
      add_row(window_of(24'd2000, 16'd0, 10'd15, 8'd90, 16'd0, 1'b0, 1'b0), 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < n_rows; i++)
         send_window(directed_rows[i].win, directed_rows[i].typed, directed_rows[i].want);

      for (phase = 1; phase <= 8; phase++) begin
         settle();
         thr = 16'($urandom_range(400, 0));
         hys = 8'($urandom_range(12, 1));
         sl  = 24'($urandom_range(3000, 20));
         al  = sl + 24'($urandom_range(20000, 0));
         case (phase)
            1: begin
               thr = '0;
               hys = '0;
               sl  = '0;
               al  = '0;
            end
            2: begin
               thr = 16'hFFFF;
               hys = 8'hFF;
               sl  = 24'hFFFFFF;
               al  = 24'hFFFFFF;
            end
            3: begin
               hys = 8'hFF;
               sl  = 24'd100;
               al  = 24'd1000;
            end
            4: hys = 8'd1;
            5: begin
               // still limit above the active limit: no moderate band
               sl = 24'd5000;
               al = 24'd2000;
            end
            8: begin
               thr = 16'd113;
               hys = 8'd5;
               sl  = 24'd100;
               al  = 24'd1000;
            end
            default: ;
         endcase
         write_regs(thr, hys, sl, al);
         // long enough to saturate the run counter
         if (phase == 3)
            for (i = 0; i < LONG_RUN; i++)
               send_window(make_window(WIN_ACTIVE, 1'b1, 1'b0), 1'b0, '0);
         run_phase(PHASE_WINDOWS);
      end

      settle();
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
